/* src/ams_pkg.sv */
// Package for the adaptive modulation selector: mode tables, register map and helpers.
// Used by the selector top level and its bound checker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ams_pkg;

  // Mode set dimensions
  localparam int unsigned MODE_COUNT  = 20;
  localparam int unsigned MODE_W      = $clog2(MODE_COUNT);
  localparam int unsigned TIER4_FIRST = 15;

  // Field and register widths
  localparam int unsigned SNR_W   = 16;
  localparam int unsigned BER_W   = 25;
  localparam int unsigned QUAL_W  = 17;
  localparam int unsigned HYST_W  = 15;
  localparam int unsigned RATE_W  = 26;
  localparam int unsigned LIM_W   = 18;
  localparam int unsigned QMIN_W  = 16;
  localparam int unsigned DB_W    = 6;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Quality margin of 0.2 in units of 2^-16
  localparam int unsigned QUAL_MARGIN = 13107;

  // Reset values of the configuration registers
  localparam logic              ADAPT_RESET = 1'b1;
  localparam logic              TIER4_RESET = 1'b0;
  localparam logic [HYST_W-1:0] HYST_RESET  = 15'd256;

  // Register word indexes (byte address bits [3:2])
  localparam logic [1:0] REG_ADAPT = 2'd0;
  localparam logic [1:0] REG_TIER4 = 2'd1;
  localparam logic [1:0] REG_HYST  = 2'd2;

  // Default mode after reset, after a tier-4 drop and when no mode fits (2FSK)
  localparam logic [MODE_W-1:0] DEFAULT_MODE = '0;

  typedef logic [MODE_W-1:0] mode_t;

  // Lower and upper SNR bound of each mode in whole dB
  localparam logic [DB_W-1:0] SNR_LO_DB [MODE_COUNT] = '{
    6'd0,  6'd8,  6'd12, 6'd18, 6'd6,  6'd10, 6'd14, 6'd16, 6'd20, 6'd22,
    6'd28, 6'd8,  6'd12, 6'd16, 6'd18, 6'd10, 6'd15, 6'd18, 6'd22, 6'd26
  };
  localparam logic [DB_W-1:0] SNR_HI_DB [MODE_COUNT] = '{
    6'd15, 6'd20, 6'd25, 6'd30, 6'd18, 6'd22, 6'd26, 6'd28, 6'd32, 6'd35,
    6'd40, 6'd20, 6'd24, 6'd28, 6'd30, 6'd25, 6'd30, 6'd33, 6'd36, 6'd40
  };

  // Minimum quality score of each mode, 65536 equals 1.0
  localparam logic [QMIN_W-1:0] QUAL_MIN [MODE_COUNT] = '{
    16'd19661, 16'd32768, 16'd45875, 16'd52429, 16'd26214,
    16'd39322, 16'd49152, 16'd52429, 16'd55706, 16'd58982,
    16'd62259, 16'd32768, 16'd42598, 16'd51118, 16'd53740,
    16'd39322, 16'd45875, 16'd49152, 16'd52429, 16'd55706
  };

  // BER limit of each mode, 2^24 equals 1.0
  localparam logic [LIM_W-1:0] BER_MAX [MODE_COUNT] = '{
    18'd167772, 18'd83886, 18'd16777, 18'd8389, 18'd167772,
    18'd83886,  18'd16777, 18'd8389,  18'd1678, 18'd1678,
    18'd839,    18'd83886, 18'd33554, 18'd13422, 18'd5033,
    18'd16777,  18'd8389,  18'd5033,  18'd3355, 18'd1678
  };

  // Data rate of each mode in bits per second
  localparam logic [RATE_W-1:0] BIT_RATE [MODE_COUNT] = '{
    26'd1200,    26'd2400,    26'd3600,     26'd4800,     26'd1200,
    26'd2400,    26'd3600,    26'd9600,     26'd37500,    26'd75000,
    26'd100000,  26'd12500,   26'd25000,    26'd37500,    26'd50000,
    26'd1000000, 26'd5000000, 26'd10000000, 26'd20000000, 26'd40000000
  };

  // Modes sorted by falling rate; equal rates keep the order of the original scan.
  // The first fitting entry of this list is the reselection result.
  localparam logic [MODE_W-1:0] PICK_ORDER [MODE_COUNT] = '{
    5'd19, 5'd18, 5'd17, 5'd16, 5'd15, 5'd10, 5'd9, 5'd14, 5'd13, 5'd8,
    5'd12, 5'd11, 5'd7,  5'd3,  5'd6,  5'd2,  5'd5, 5'd1,  5'd4,  5'd0
  };

  // True for the broadband SOQPSK modes
  function automatic logic is_tier4(input logic [MODE_W-1:0] m);
    return (m >= MODE_W'(TIER4_FIRST)) && (m < MODE_W'(MODE_COUNT));
  endfunction

endpackage : ams_pkg

`default_nettype wire

/* src/adaptive_modulation_selector.sv */
// Adaptive modulation selector: keeps the current and prior mode, reselects on SNR, BER and quality,
// and applies mode requests. Depends on ams_pkg for the mode tables and register map.
// Flow: an accepted transaction passes through the input register, where the table compare and
// priority pick run, into the result register; one transaction per cycle is sustained while the
// result channel is not stalled.
// Reset: asynchronous, active low; both modes return to 2FSK and the configuration registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_modulation_selector (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ams_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ams_pkg::PDATA_W-1:0] pwdata,
  output logic      [ams_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  // Input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        cmd_i,
  input  wire logic signed [ams_pkg::SNR_W-1:0] snr_level_i,
  input  wire logic [ams_pkg::BER_W-1:0]   error_rate_i,
  input  wire logic [ams_pkg::QUAL_W-1:0]  quality_i,
  input  wire logic [ams_pkg::MODE_W-1:0]  mode_request_i,
  // Result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [ams_pkg::MODE_W-1:0]  active_mode_o,
  output logic      [ams_pkg::MODE_W-1:0]  prior_mode_o,
  output logic      [ams_pkg::RATE_W-1:0]  bit_rate_o,
  output logic                             mode_changed_o,
  output logic                             request_rejected_o
);

  import ams_pkg::*;

  localparam int unsigned CMP_W = 18;

  // Configuration registers
  logic              adapt_en_q;
  logic              tier4_en_q;
  logic [HYST_W-1:0] hyst_q;
  logic              cfg_wr;

  // Input register
  logic                    in_valid_q;
  logic                    cmd_q;
  logic signed [SNR_W-1:0] snr_q;
  logic [BER_W-1:0]        ber_q;
  logic [QUAL_W-1:0]       qual_q;
  logic [MODE_W-1:0]       req_q;

  // Mode state
  mode_t cur_q, cur_d;
  mode_t prev_q, prev_d;

  // Result register
  logic              out_valid_q;
  mode_t             res_active_q;
  mode_t             res_prior_q;
  logic [RATE_W-1:0] res_rate_q;
  logic              res_changed_q;
  logic              res_rejected_q;
  logic              rejected;

  logic advance;
  logic in_take;

  // Compare operands
  mode_t                   base_cur;
  mode_t                   base_prev;
  mode_t                   pick;
  logic                    fallback;
  logic signed [CMP_W-1:0] snr_x;
  logic signed [CMP_W-1:0] up_bound;
  logic signed [CMP_W-1:0] low_bound;
  logic signed [CMP_W-1:0] qual_x;
  logic signed [CMP_W-1:0] qmin_x;
  logic signed [CMP_W-1:0] qlow_x;
  logic [BER_W-1:0]        lim_x;
  logic                    go_up;
  logic                    go_down;
  logic [MODE_COUNT-1:0]   fit;

  // APB register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adapt_en_q <= ADAPT_RESET;
      tier4_en_q <= TIER4_RESET;
      hyst_q     <= HYST_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ADAPT: adapt_en_q <= pwdata[0];
        REG_TIER4: tier4_en_q <= pwdata[0];
        REG_HYST:  hyst_q     <= pwdata[HYST_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ADAPT: prdata = {{(PDATA_W-1){1'b0}}, adapt_en_q};
      REG_TIER4: prdata = {{(PDATA_W-1){1'b0}}, tier4_en_q};
      REG_HYST:  prdata = {{(PDATA_W-HYST_W){1'b0}}, hyst_q};
      default:   prdata = '0;
    endcase
  end

  // Handshake: the held transaction moves on when the result register is free or drains
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= cmd_i;
      snr_q  <= snr_level_i;
      ber_q  <= error_rate_i;
      qual_q <= quality_i;
      req_q  <= mode_request_i;
    end
  end

  // Broadband modes drop back to 2FSK once tier 4 is switched off
  assign fallback  = !tier4_en_q && is_tier4(cur_q);
  assign base_cur  = fallback ? DEFAULT_MODE : cur_q;
  assign base_prev = fallback ? DEFAULT_MODE : prev_q;

  // Operating-region test against the current mode
  assign snr_x     = CMP_W'(snr_q);
  assign up_bound  = $signed({4'b0, SNR_HI_DB[base_cur], 8'b0}) + $signed({3'b0, hyst_q});
  assign low_bound = $signed({4'b0, SNR_LO_DB[base_cur], 8'b0}) - $signed({3'b0, hyst_q});
  assign qual_x    = $signed({1'b0, qual_q});
  assign qmin_x    = $signed({2'b0, QUAL_MIN[base_cur]});
  assign qlow_x    = qmin_x - CMP_W'(QUAL_MARGIN);
  assign lim_x     = BER_W'(BER_MAX[base_cur]);

  assign go_up   = (snr_x > up_bound) && (ber_q < lim_x) && (qual_x > qmin_x);
  assign go_down = (snr_x < low_bound) || (ber_q > lim_x) || (qual_x < qlow_x);

  // Window, BER and tier-4 enable test of every mode in parallel
  always_comb begin
    for (int m = 0; m < MODE_COUNT; m++) begin
      fit[m] = (snr_x >= $signed({4'b0, SNR_LO_DB[m], 8'b0}))
            && (snr_x <= $signed({4'b0, SNR_HI_DB[m], 8'b0}))
            && (ber_q <= BER_W'(BER_MAX[m]))
            && (tier4_en_q || !is_tier4(MODE_W'(m)));
    end
  end

  // Priority pick: the earliest fitting entry of the rate-sorted list, else 2FSK
  always_comb begin
    pick = DEFAULT_MODE;
    for (int i = MODE_COUNT - 1; i >= 0; i--) begin
      if (fit[PICK_ORDER[i]]) begin
        pick = PICK_ORDER[i];
      end
    end
  end

  // Next mode state for the transaction in the input register
  always_comb begin
    cur_d    = base_cur;
    prev_d   = base_prev;
    rejected = 1'b0;
    if (cmd_q) begin
      if (req_q < MODE_W'(MODE_COUNT)) begin
        if (is_tier4(req_q) && !tier4_en_q) begin
          rejected = 1'b1;
        end else begin
          cur_d  = req_q;
          prev_d = req_q;
        end
      end
    end else if (adapt_en_q && (go_up || go_down) && (pick != base_cur)) begin
      prev_d = base_cur;
      cur_d  = pick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= DEFAULT_MODE;
      prev_q <= DEFAULT_MODE;
    end else if (advance) begin
      cur_q  <= cur_d;
      prev_q <= prev_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_active_q   <= cur_d;
      res_prior_q    <= prev_d;
      res_rate_q     <= BIT_RATE[cur_d];
      res_changed_q  <= (cur_d != cur_q);
      res_rejected_q <= rejected;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign active_mode_o      = res_active_q;
  assign prior_mode_o       = res_prior_q;
  assign bit_rate_o         = res_rate_q;
  assign mode_changed_o     = res_changed_q;
  assign request_rejected_o = res_rejected_q;

endmodule : adaptive_modulation_selector

`default_nettype wire

/* src/ams_checker.sv */
// Port-level checker for the adaptive modulation selector, bound to its top level.
// Depends on ams_pkg for the mode count and the tier-4 boundary.
`timescale 1ns / 1ps
`default_nettype none

module ams_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  input  wire logic [ams_pkg::MODE_W-1:0]  active_mode_o,
  input  wire logic [ams_pkg::MODE_W-1:0]  prior_mode_o,
  input  wire logic                        mode_changed_o,
  input  wire logic                        request_rejected_o
);

  import ams_pkg::*;

  logic  seen_q;
  mode_t last_q;

  // Track the mode shown by the last delivered result transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      last_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      seen_q <= 1'b1;
      last_q <= active_mode_o;
    end
  end

  // A stalled result holds its mode fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(active_mode_o)
      && $stable(prior_mode_o))
    else $error("stalled result changed");

  // Both reported modes of a valid result are always legal codes.
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (active_mode_o < MODE_W'(MODE_COUNT))
      && (prior_mode_o < MODE_W'(MODE_COUNT)))
    else $error("illegal mode code reported");

  // A refused request can only happen with tier 4 off, so no broadband mode is active.
  a_reject_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && request_rejected_o |-> active_mode_o < MODE_W'(TIER4_FIRST))
    else $error("broadband mode active after a refused request");

  // Without a change flag the mode equals the one of the previous transaction.
  a_change_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q && !mode_changed_o |-> active_mode_o == last_q)
    else $error("mode moved without the change flag");

endmodule : ams_checker

bind adaptive_modulation_selector ams_checker u_ams_checker (.*);

`default_nettype wire
